[hdl/sad_pkg.sv]
// Shared types and constants for the SAD stereo disparity block.
package sad_pkg;

	localparam int RowW   = 11;
	localparam int ColW   = 10;
	localparam int PixW   = 8;
	localparam int HalfCfgW  = 3;
	localparam int WidthCfgW = 11;
	localparam int CfgDataW  = 11;
	localparam int CfgIdxW   = 1;
	localparam int DispW  = 7;

	localparam logic [CfgIdxW-1:0] REG_WINDOW_HALF = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH = 1'd1;

	localparam logic [HalfCfgW-1:0]  HALF_RESET  = 3'd5;
	localparam logic [WidthCfgW-1:0] WIDTH_RESET = 11'd640;
	localparam logic [WidthCfgW-1:0] WIDTH_MIN   = 11'd16;
	localparam int WidthLimit = 1024;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_CMP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic next_d;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic emit_now;
		logic last_ij;
		logic last_d;
		logic out_free;
	} sts_t;

endpackage

[hdl/sad_ctrl.sv]
// Sequencer for the SAD sweep over window taps and disparity candidates.
module sad_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sad_pkg::sts_t sts,
	output sad_pkg::cmd_t cmd
);

	sad_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sad_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			sad_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.emit_now) state_d = sad_pkg::ST_SWEEP;
				end
			end
			sad_pkg::ST_SWEEP: begin
				cmd.step = 1'b1;
				if (sts.last_ij) state_d = sad_pkg::ST_DRAIN;
			end
			sad_pkg::ST_DRAIN: begin
				state_d = sad_pkg::ST_CMP;
			end
			sad_pkg::ST_CMP: begin
				cmd.next_d = 1'b1;
				state_d = sts.last_d ? sad_pkg::ST_EMIT : sad_pkg::ST_SWEEP;
			end
			sad_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d = sad_pkg::ST_IDLE;
				end
			end
			default: state_d = sad_pkg::ST_IDLE;
		endcase
	end

endmodule

[hdl/sad_dp.sv]
// Line stores, window address generation, SAD accumulation and best-candidate tracking.
module sad_dp #(
	parameter int MAX_DISPARITY = 127,
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_HALF      = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sad_pkg::cmd_t                     cmd,
	output sad_pkg::sts_t                     sts,
	input  logic [sad_pkg::PixW-1:0]          left_pixel,
	input  logic [sad_pkg::PixW-1:0]          right_pixel,
	input  logic                              frame_start,
	input  logic [$clog2(MAX_HALF+1)-1:0]     half,
	input  logic [sad_pkg::WidthCfgW-1:0]     width,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sad_pkg::DispW-1:0]         disparity,
	output logic [sad_pkg::RowW-1:0]          centre_row,
	output logic [sad_pkg::ColW-1:0]          centre_col
);

	localparam int Slots = 2 * MAX_HALF + 1;
	localparam int SlotW = $clog2(Slots);
	localparam int Depth = Slots * MAX_WIDTH;
	localparam int AW    = $clog2(Depth);
	localparam int HW    = $clog2(MAX_HALF + 1);
	localparam int TapW  = $clog2(Slots);
	localparam int DW    = (MAX_DISPARITY > 1) ? $clog2(MAX_DISPARITY) : 1;
	localparam int SW    = $clog2(Slots * Slots * 255 + 1);
	localparam int RW    = sad_pkg::RowW;
	localparam int CW    = sad_pkg::ColW;

	logic [sad_pkg::PixW-1:0] left_mem  [Depth];
	logic [sad_pkg::PixW-1:0] right_mem [Depth];

	logic [RW-1:0]    row_q;
	logic [CW-1:0]    col_q;
	logic [SlotW-1:0] slot_q;

	logic [RW-1:0]    r;
	logic [CW-1:0]    c;
	logic [SlotW-1:0] sr;
	logic [CW:0]      two_h;
	logic [AW-1:0]    wr_addr;
	logic [SlotW:0]   top_tmp;
	logic [SlotW-1:0] top_slot;
	logic [CW-1:0]    dspan;
	logic [DW-1:0]    dlim;
	logic             emit_now;

	always_comb begin
		r  = frame_start ? '0 : row_q;
		c  = frame_start ? '0 : col_q;
		sr = frame_start ? '0 : slot_q;
		if ({{(32-CW){1'b0}}, c} >= MAX_WIDTH) c = CW'(MAX_WIDTH - 1);
		two_h = (CW+1)'({half, 1'b0});
		wr_addr = AW'(sr) * AW'(MAX_WIDTH) + AW'(c);
		emit_now = ({1'b0, r} >= (RW+1)'(two_h)) && ({1'b0, c} >= two_h);
		top_tmp = (SlotW+1)'(sr) + (SlotW+1)'(Slots) - (SlotW+1)'(two_h);
		top_slot = (top_tmp >= (SlotW+1)'(Slots)) ? SlotW'(top_tmp - (SlotW+1)'(Slots))
		                                          : SlotW'(top_tmp);
		dspan = c - CW'(two_h);
		dlim = ({2'b0, dspan} > (CW+2)'(MAX_DISPARITY - 1)) ? DW'(MAX_DISPARITY - 1)
		                                                   : DW'(dspan);
	end

	assign sts.emit_now = emit_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (cmd.load) begin
			if ({1'b0, c} + (CW+1)'(1) >= width) begin
				col_q <= '0;
				row_q <= r + RW'(1);
				if (r == '1 || sr == SlotW'(Slots - 1)) slot_q <= '0;
				else slot_q <= sr + SlotW'(1);
			end else begin
				col_q  <= c + CW'(1);
				row_q  <= r;
				slot_q <= sr;
			end
		end
	end

	// per-item working registers
	logic [RW-1:0]    r_q;
	logic [CW-1:0]    c_q;
	logic [HW-1:0]    h_q;
	logic [SlotW-1:0] top_q;
	logic [SlotW-1:0] slot_i_q;
	logic [TapW-1:0]  i_q, j_q;
	logic [DW-1:0]    d_q, dlim_q, bestd_q;
	logic [SW-1:0]    sum_q, best_q;
	logic [TapW-1:0]  two_h_t;
	logic [CW-1:0]    cl, cr;
	logic [AW-1:0]    rl_addr, rr_addr;

	assign two_h_t = TapW'({h_q, 1'b0});
	assign cl      = c_q - CW'({h_q, 1'b0}) + CW'(j_q);
	assign cr      = cl - CW'(d_q);
	assign rl_addr = AW'(slot_i_q) * AW'(MAX_WIDTH) + AW'(cl);
	assign rr_addr = AW'(slot_i_q) * AW'(MAX_WIDTH) + AW'(cr);
	assign sts.last_ij = (i_q == two_h_t) && (j_q == two_h_t);
	assign sts.last_d  = (d_q == dlim_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			left_mem[wr_addr]  <= left_pixel;
			right_mem[wr_addr] <= right_pixel;
		end
	end

	logic [sad_pkg::PixW-1:0] lpix_s1, rpix_s1;
	logic                     rd_vld_s1;

	always_ff @(posedge clk) begin
		lpix_s1 <= left_mem[rl_addr];
		rpix_s1 <= right_mem[rr_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_vld_s1 <= 1'b0;
		else rd_vld_s1 <= cmd.step;
	end

	logic [sad_pkg::PixW-1:0] adiff;
	assign adiff = (lpix_s1 >= rpix_s1) ? lpix_s1 - rpix_s1 : rpix_s1 - lpix_s1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q      <= r;
			c_q      <= c;
			h_q      <= half;
			top_q    <= top_slot;
			slot_i_q <= top_slot;
			i_q      <= '0;
			j_q      <= '0;
			d_q      <= '0;
			dlim_q   <= dlim;
			sum_q    <= '0;
			best_q   <= '1;
			bestd_q  <= '0;
		end else if (cmd.next_d) begin
			if (sum_q < best_q) begin
				best_q  <= sum_q;
				bestd_q <= d_q;
			end
			d_q      <= d_q + DW'(1);
			sum_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			slot_i_q <= top_q;
		end else begin
			if (rd_vld_s1) sum_q <= sum_q + SW'(adiff);
			if (cmd.step) begin
				if (j_q == two_h_t) begin
					j_q <= '0;
					i_q <= i_q + TapW'(1);
					slot_i_q <= (slot_i_q == SlotW'(Slots - 1)) ? '0 : slot_i_q + SlotW'(1);
				end else begin
					j_q <= j_q + TapW'(1);
				end
			end
		end
	end

	// output word register
	logic out_valid_q;
	logic [sad_pkg::DispW-1:0] disp_q;
	logic [RW-1:0] crow_q;
	logic [CW-1:0] ccol_q;

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.push) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			disp_q <= sad_pkg::DispW'(bestd_q);
			crow_q <= r_q - RW'(h_q);
			ccol_q <= c_q - CW'(h_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign disparity  = disp_q;
	assign centre_row = crow_q;
	assign centre_col = ccol_q;

endmodule

[hdl/sad_stereo_disparity_top.sv]
// SAD block-matching stereo disparity: top level with configuration registers.
// Usage: feed rectified left/right pixel pairs in raster order on the input
// channel (in_valid/in_ready), frame_start high on the first pixel of a frame.
// Each accepted word is written to the line stores. When the pixel completes
// a (2h+1)x(2h+1) window, a disparity word for the window centre appears on
// the output channel (out_valid/out_ready) with its row and column.
// A word that completes no window is taken while the block stays idle. A word
// that completes a window holds in_ready low while, for each candidate d from
// 0 to D, D being min(MAX_DISPARITY-1, x-2h), the block sweeps the (2h+1)^2
// window taps, one window tap per cycle through the single read port of each
// line store, then drains and compares the sum, and at last emits the result.
// The result sits in an output register: the next input word is taken while it
// waits; if the receiver stalls, the following result holds until it is taken.
// Reset clears row/column counters, the output valid and the state machine and
// loads window_half 5 and image_width 640; line store contents are undefined
// until written. Write configuration only while the block is idle.
module sad_stereo_disparity_top #(
	parameter int MAX_DISPARITY = 127,
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_HALF      = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [sad_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [sad_pkg::CfgDataW-1:0]   cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sad_pkg::PixW-1:0]       left_pixel,
	input  logic [sad_pkg::PixW-1:0]       right_pixel,
	input  logic                           frame_start,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sad_pkg::DispW-1:0]      disparity,
	output logic [sad_pkg::RowW-1:0]       centre_row,
	output logic [sad_pkg::ColW-1:0]       centre_col
);

	localparam int HW = $clog2(MAX_HALF + 1);
	localparam int WidthCap = (MAX_WIDTH < sad_pkg::WidthLimit) ? MAX_WIDTH
	                                                            : sad_pkg::WidthLimit;

	logic [sad_pkg::HalfCfgW-1:0]  half_q;
	logic [sad_pkg::WidthCfgW-1:0] width_q;
	logic [HW-1:0]                 half_eff;
	logic [sad_pkg::WidthCfgW-1:0] width_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q  <= sad_pkg::HALF_RESET;
			width_q <= sad_pkg::WIDTH_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sad_pkg::REG_WINDOW_HALF: half_q  <= sad_pkg::HalfCfgW'(cfg_wdata);
				sad_pkg::REG_IMAGE_WIDTH: width_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (half_q == '0) half_eff = HW'(1);
		else if (32'(half_q) > MAX_HALF) half_eff = HW'(MAX_HALF);
		else half_eff = HW'(half_q);
		if (width_q < sad_pkg::WIDTH_MIN) width_eff = sad_pkg::WIDTH_MIN;
		else if (32'(width_q) > WidthCap) width_eff = sad_pkg::WidthCfgW'(WidthCap);
		else width_eff = width_q;
	end

	sad_pkg::cmd_t cmd;
	sad_pkg::sts_t sts;

	sad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sad_dp #(
		.MAX_DISPARITY (MAX_DISPARITY),
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_HALF      (MAX_HALF)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.left_pixel  (left_pixel),
		.right_pixel (right_pixel),
		.frame_start (frame_start),
		.half        (half_eff),
		.width       (width_eff),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.disparity   (disparity),
		.centre_row  (centre_row),
		.centre_col  (centre_col)
	);

endmodule
